@@ src/bsc_pkg.sv @@
// Shared types and constants for the breakpoint and step controller.
// No dependencies; imported by all design and verification files.
package bsc_pkg;

    localparam int BSC_ENTRIES = 16;

    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 4;
    localparam int IN_DATA_W = 40;   // pc_address, inst_length, zero fill
    localparam int IN_USER_W = 4;    // mode, is_call
    localparam int OUT_DATA_W = 8;   // halt, run_state, hit, found, full, zero fill

    typedef enum logic [2:0] {
        MODE_INSTR   = 3'd0,
        MODE_STEP_IN = 3'd1,
        MODE_STEP_OV = 3'd2,
        MODE_RUN     = 3'd3,
        MODE_TERM    = 3'd4,
        MODE_TOGGLE  = 3'd5,
        MODE_REMOVE  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_SINGLE = 2'd0,
        ST_RUN    = 2'd1,
        ST_OVER   = 2'd2,
        ST_TERM   = 2'd3
    } run_state_t;

    // Request from the controller to the breakpoint table
    typedef struct packed {
        logic toggle;
        logic remove;
    } tbl_req_t;

    // Lookup results from the breakpoint table
    typedef struct packed {
        logic hit;
        logic found;
        logic full;
    } tbl_rsp_t;

endpackage

@@ src/bsc_bp_table.sv @@
// Breakpoint table: address, valid and enable per entry, compared in parallel.
// Depends on bsc_pkg for the request and response structs.
module bsc_bp_table
    import bsc_pkg::*;
#(
    parameter int ENTRIES = BSC_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ADDR_W-1:0]   lookup_addr,
    input  logic                update,     // apply req this cycle
    input  tbl_req_t            req,
    output tbl_rsp_t            rsp
);

    logic [ADDR_W-1:0] addr_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] enabled_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [ENTRIES-1:0] enabled_next;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] alloc;
    logic               found;

    // Addresses are unique among valid entries, so at most one match
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (addr_reg[i] == lookup_addr);
        end
    end

    assign found    = |match;
    assign free_vec = ~valid_reg;
    assign free_oh  = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});

    assign rsp.hit   = |(match & enabled_reg);
    assign rsp.found = found;
    assign rsp.full  = !found && !(|free_vec);

    assign alloc = (update && req.toggle && !found) ? free_oh : '0;

    always_comb
    begin
        valid_next   = valid_reg;
        enabled_next = enabled_reg;
        if (update && req.toggle)
        begin
            enabled_next = (enabled_reg ^ match) | alloc;
            valid_next   = valid_reg | alloc;
        end
        else if (update && req.remove)
        begin
            valid_next   = valid_reg & ~match;
            enabled_next = enabled_reg & ~match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            enabled_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            enabled_reg <= enabled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (alloc[i])
            begin
                addr_reg[i] <= lookup_addr;
            end
        end
    end

endmodule

@@ src/breakpoint_step_controller_core.sv @@
// Top level of the breakpoint and step controller.
// Depends on bsc_pkg and bsc_bp_table.
//
// Usage:
//   s_* carries one transaction per instruction or debugger command.
//   s_tuser holds the command code and the call flag, s_tdata the address
//   and the instruction length. Every input transaction yields exactly one
//   m_* transaction with halt, run state, hit, found and full flags.
//   cfg_valid/cfg_data write break_on_entry; the write also reloads the run
//   state (1 single-step, 0 running). Write it only while no transaction is
//   in flight.
// Timing:
//   One transaction per cycle while m_tready is high. The result register loads
//   from the input register through a single pass of table compare and run-state
//   logic, whose path is set by the ENTRIES parallel 32-bit comparators.
// Reset:
//   The breakpoint table is emptied and the run state is single-step.
// Stall:
//   When m_tready is low the result holds, the input register holds one more
//   transaction, and s_tready drops until the result is taken.
module breakpoint_step_controller_core
    import bsc_pkg::*;
#(
    parameter int ENTRIES = BSC_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,       // break_on_entry
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,        // [31:0] pc_address, [35:32] inst_length
    input  logic [IN_USER_W-1:0]  s_tuser,        // [2:0] mode, [3] is_call
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata         // [0] halt, [2:1] run_state,
                                                  // [3] breakpoint_hit,
                                                  // [4] entry_found, [5] table_full
);

    // Input register
    logic               in_valid_reg;
    logic [2:0]         in_mode_reg;
    logic [ADDR_W-1:0]  in_pc_reg;
    logic               in_call_reg;
    logic [LEN_W-1:0]   in_len_reg;

    // Result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    // Run state
    run_state_t         mode_state_reg, mode_state_next;
    logic [ADDR_W-1:0]  return_target_reg, return_target_next;
    logic [ADDR_W-1:0]  last_address_reg, last_address_next;
    logic [LEN_W-1:0]   last_length_reg, last_length_next;
    logic               last_is_call_reg, last_is_call_next;
    logic               have_last_reg, have_last_next;

    logic      advance;
    tbl_req_t  tbl_req;
    tbl_rsp_t  tbl_rsp;
    run_state_t st_tmp;
    logic      halt, hit, found, full;

    // Move the held transaction into the result register when there is room
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign tbl_req.toggle = (in_mode_reg == MODE_TOGGLE);
    assign tbl_req.remove = (in_mode_reg == MODE_REMOVE);

    bsc_bp_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_addr (in_pc_reg),
        .update      (advance),
        .req         (tbl_req),
        .rsp         (tbl_rsp)
    );

    always_comb
    begin
        mode_state_next    = mode_state_reg;
        return_target_next = return_target_reg;
        last_address_next  = last_address_reg;
        last_length_next   = last_length_reg;
        last_is_call_next  = last_is_call_reg;
        have_last_next     = have_last_reg;
        halt  = 1'b0;
        hit   = 1'b0;
        found = 1'b0;
        full  = 1'b0;
        st_tmp = mode_state_reg;

        unique case (in_mode_reg)
            MODE_INSTR:
            begin
                last_address_next = in_pc_reg;
                last_length_next  = in_len_reg;
                last_is_call_next = in_call_reg;
                have_last_next    = 1'b1;
                hit = tbl_rsp.hit;
                // An enabled breakpoint forces single-step from any state
                st_tmp = hit ? ST_SINGLE : mode_state_reg;
                mode_state_next = st_tmp;
                if (st_tmp == ST_SINGLE)
                begin
                    halt = 1'b1;
                end
                else if (st_tmp == ST_OVER && in_pc_reg == return_target_reg)
                begin
                    // Return address reached: drop back to single-step
                    mode_state_next    = ST_SINGLE;
                    return_target_next = '0;
                    halt = 1'b1;
                end
            end
            MODE_STEP_IN:
            begin
                // No state change
            end
            MODE_STEP_OV:
            begin
                // Arm only on a call; otherwise it is a plain step
                if (mode_state_reg != ST_OVER && have_last_reg && last_is_call_reg)
                begin
                    mode_state_next    = ST_OVER;
                    return_target_next = last_address_reg
                                       + {{(ADDR_W-LEN_W){1'b0}}, last_length_reg};
                end
            end
            MODE_RUN:
            begin
                mode_state_next = ST_RUN;
            end
            MODE_TERM:
            begin
                mode_state_next = ST_TERM;
            end
            MODE_TOGGLE:
            begin
                found = tbl_rsp.found;
                full  = tbl_rsp.full;
            end
            MODE_REMOVE:
            begin
                found = tbl_rsp.found;
            end
            default:
            begin
                // Unused code: report run state only
            end
        endcase

        out_data_next = {2'b00, full, found, hit, mode_state_next, halt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            mode_state_reg    <= ST_SINGLE;
            return_target_reg <= '0;
            last_address_reg  <= '0;
            last_length_reg   <= '0;
            last_is_call_reg  <= 1'b0;
            have_last_reg     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                // Reload the run state from break_on_entry
                mode_state_reg <= cfg_data ? ST_SINGLE : ST_RUN;
            end
            else if (advance)
            begin
                mode_state_reg    <= mode_state_next;
                return_target_reg <= return_target_next;
                last_address_reg  <= last_address_next;
                last_length_reg   <= last_length_next;
                last_is_call_reg  <= last_is_call_next;
                have_last_reg     <= have_last_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser[2:0];
            in_call_reg <= s_tuser[3];
            in_pc_reg   <= s_tdata[ADDR_W-1:0];
            in_len_reg  <= s_tdata[ADDR_W+LEN_W-1:ADDR_W];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A halt always leaves the unit in single-step
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[0]) |-> (out_data_reg[2:1] == ST_SINGLE))
        else $error("halt reported outside single-step");

    // A breakpoint hit always halts
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[3]) |-> out_data_reg[0])
        else $error("breakpoint hit without halt");

    // Full and found never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg[4] && out_data_reg[5]))
        else $error("table_full with entry_found");

    // Input back-pressure only when both registers are occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready low with room available");

    // A stalled result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(out_data_reg))
        else $error("result changed while stalled");

endmodule

@@ verif/bsc_step_checker.sv @@
// Checker for the breakpoint and step controller: watches the config, input and
// result channels, predicts every result and compares it field by field.
// Depends on bsc_pkg.
module bsc_step_checker
    import bsc_pkg::*;
#(
    parameter int ENTRIES = BSC_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic       halt;
        run_state_t run_st;
        logic       hit;
        logic       found;
        logic       full;
    } response_t;

    // Shadow of the breakpoint table and the run state
    logic [ADDR_W-1:0] bp_addr [ENTRIES];
    logic              bp_used [ENTRIES];
    logic              bp_on   [ENTRIES];
    run_state_t        run_st;
    logic [ADDR_W-1:0] ret_addr;
    logic [ADDR_W-1:0] prev_pc;
    logic [LEN_W-1:0]  prev_len;
    logic              prev_call;
    logic              seen_instr;

    response_t pending_responses[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("bsc_step_checker: %0t: %s got %0h expected %0h",
                     $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic int lookup_bp(input logic [ADDR_W-1:0] pc);
        int i;
        int slot;
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
            if (slot < 0 && bp_used[i] && bp_addr[i] == pc)
                slot = i;
        return slot;
    endfunction

    function automatic response_t expected_response(input logic [2:0] mode,
                                                    input logic [ADDR_W-1:0] pc,
                                                    input logic call,
                                                    input logic [LEN_W-1:0] len);
        response_t r;
        int        i;
        int        slot;
        r = '0;
        case (mode)
            MODE_INSTR:
            begin
                prev_pc    = pc;
                prev_len   = len;
                prev_call  = call;
                seen_instr = 1'b1;
                for (i = 0; i < ENTRIES; i++)
                    if (bp_used[i] && bp_on[i] && bp_addr[i] == pc)
                        r.hit = 1'b1;
                // a hit wins over every run state
                if (r.hit)
                    run_st = ST_SINGLE;
                if (run_st == ST_SINGLE)
                    r.halt = 1'b1;
                else if (run_st == ST_OVER && pc == ret_addr)
                begin
                    run_st   = ST_SINGLE;
                    ret_addr = '0;
                    r.halt   = 1'b1;
                end
            end
            MODE_STEP_OV:
            begin
                if (run_st != ST_OVER && seen_instr && prev_call)
                begin
                    run_st   = ST_OVER;
                    ret_addr = prev_pc + ADDR_W'(prev_len);
                end
            end
            MODE_RUN:
                run_st = ST_RUN;
            MODE_TERM:
                run_st = ST_TERM;
            MODE_TOGGLE:
            begin
                slot = lookup_bp(pc);
                if (slot >= 0)
                begin
                    r.found     = 1'b1;
                    bp_on[slot] = !bp_on[slot];
                end
                else
                begin
                    for (i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !bp_used[i])
                            slot = i;
                    if (slot < 0)
                        r.full = 1'b1;
                    else
                    begin
                        bp_addr[slot] = pc;
                        bp_used[slot] = 1'b1;
                        bp_on[slot]   = 1'b1;
                    end
                end
            end
            MODE_REMOVE:
            begin
                slot = lookup_bp(pc);
                if (slot >= 0)
                begin
                    r.found       = 1'b1;
                    bp_used[slot] = 1'b0;
                    bp_on[slot]   = 1'b0;
                end
            end
            default:
                ; // step into and the unused code leave everything alone
        endcase
        r.run_st = run_st;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                bp_addr[i] = '0;
                bp_used[i] = 1'b0;
                bp_on[i]   = 1'b0;
            end
            run_st     = ST_SINGLE;
            ret_addr   = '0;
            prev_pc    = '0;
            prev_len   = '0;
            prev_call  = 1'b0;
            seen_instr = 1'b0;
            pending_responses.delete();
            outstanding = 0;
        end
        else
        begin
            // A config write reloads the run state; the table is kept
            if (cfg_valid && cfg_ready)
                run_st = cfg_data ? ST_SINGLE : ST_RUN;

            if (m_tvalid && m_tready)
            begin
                if (pending_responses.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata, 0);
                else
                begin
                    want = pending_responses.pop_front();
                    if (m_tdata[0] !== want.halt)
                        report_mismatch("halt", m_tdata[0], want.halt);
                    if (m_tdata[2:1] !== want.run_st)
                        report_mismatch("run_state", m_tdata[2:1], want.run_st);
                    if (m_tdata[3] !== want.hit)
                        report_mismatch("breakpoint_hit", m_tdata[3], want.hit);
                    if (m_tdata[4] !== want.found)
                        report_mismatch("entry_found", m_tdata[4], want.found);
                    if (m_tdata[5] !== want.full)
                        report_mismatch("table_full", m_tdata[5], want.full);
                    if (m_tdata[OUT_DATA_W-1:6] !== '0)
                        report_mismatch("zero fill", m_tdata[OUT_DATA_W-1:6], 0);
                end
            end

            // Append the prediction at the tail of the queue
            if (s_tvalid && s_tready)
                pending_responses = {pending_responses, expected_response(
                    s_tuser[2:0], s_tdata[ADDR_W-1:0], s_tuser[3],
                    s_tdata[ADDR_W+LEN_W-1:ADDR_W])};

            outstanding = pending_responses.size();
        end
    end

endmodule

@@ verif/tb_breakpoint_step_controller_core.sv @@
// Testbench top for breakpoint_step_controller_core: clock, reset, stimulus
// and verdict. Depends on bsc_pkg, the core and bsc_step_checker.
module tb_breakpoint_step_controller_core;
    import bsc_pkg::*;

    // Code 7 is outside the command set; the core must treat it as a no-op
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int POOL_SIZE       = 24;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // [31:0] pc_address, [35:32] inst_length
    logic [IN_USER_W-1:0]  s_tuser;     // [2:0] mode, [3] is_call
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // [0] halt, [2:1] run_state, [3] hit,
                                        // [4] found, [5] full
    int                    mismatches;
    int                    outstanding;

    // Idling controls for the sender and the receiver, and the watchdog's idle count
    logic                  calm;
    logic                  stall_request;
    int                    quiet_cycles;

    // Program-flow generator state for well-formed instruction streams
    logic [ADDR_W-1:0]     gen_pc;
    logic [ADDR_W-1:0]     gen_ret;
    logic                  ret_armed;
    logic [ADDR_W-1:0]     addr_pool [POOL_SIZE];

    breakpoint_step_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bsc_step_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Gap length in cycles: none while calm, else mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one transaction at the falling edge and hold it until accepted.
    // Enter and leave at a falling edge; valid stays high for a following item.
    task automatic send(input logic [2:0] mode, input logic [ADDR_W-1:0] pc,
                        input logic call, input logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-ADDR_W-LEN_W){1'b0}}, len, pc};
        s_tuser  <= {call, mode};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drop valid, wait for every result, then let the pipeline run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_break_on_entry(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a plausible program: sequential flow, calls with returns,
    // debugger commands and breakpoint edits on a small address pool.
    // A slice of items is pure noise.
    task automatic send_random_item();
        int                r;
        int                pick;
        logic [2:0]        mode;
        logic [ADDR_W-1:0] pc;
        logic              call;
        logic [LEN_W-1:0]  len;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        pc   = $urandom();
        call = 1'($urandom_range(0, 1));
        len  = LEN_W'($urandom_range(1, 15));
        if (r < 8)
            mode = 3'($urandom_range(0, 7));
        else if (r < 55)
        begin
            mode = MODE_INSTR;
            call = ($urandom_range(0, 3) == 0);
            if (ret_armed && $urandom_range(0, 3) == 0)
            begin
                pc        = gen_ret;
                ret_armed = 1'b0;
            end
            else if (pick < 65)
                pc = gen_pc;
            else if (pick < 88)
                pc = addr_pool[$urandom_range(0, POOL_SIZE-1)];
            // follow a call into its target and remember where it comes back
            if (call)
            begin
                gen_ret   = pc + ADDR_W'(len);
                ret_armed = 1'b1;
                gen_pc    = addr_pool[$urandom_range(0, POOL_SIZE-1)];
            end
            else
                gen_pc = pc + ADDR_W'(len);
        end
        else if (r < 60)
            mode = MODE_STEP_IN;
        else if (r < 70)
            mode = MODE_STEP_OV;
        else if (r < 77)
            mode = MODE_RUN;
        else if (r < 79)
            mode = MODE_TERM;
        else if (r < 91)
        begin
            mode = MODE_TOGGLE;
            if (pick < 70)
                pc = addr_pool[$urandom_range(0, POOL_SIZE-1)];
            else if (pick < 85)
                pc = gen_pc;
        end
        else if (r < 99)
        begin
            mode = MODE_REMOVE;
            if (pick < 80)
                pc = addr_pool[$urandom_range(0, POOL_SIZE-1)];
            else
                pc = gen_pc;
        end
        else
            mode = MODE_UNUSED;
        send(mode, pc, call, len);
    endtask

    // Receiver: random back-pressure, plus one long hold on request so the
    // core fills up and stalls its input
    initial
    begin : receiver
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_breakpoint_step_controller_core: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int   ph;
        logic boot_single;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        calm          = 1'b0;
        stall_request = 1'b0;
        quiet_cycles  = 0;
        gen_pc        = 32'h0040_0000;
        gen_ret       = '0;
        ret_armed     = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = gen_pc;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting in single-step from reset.
        // Step over before any instruction was seen: ignored
        send(MODE_STEP_OV, 32'h0, 1'b1, 4'd1);
        send(MODE_INSTR, 32'h0, 1'b0, 4'd1);
        // last instruction is not a call: plain step
        send(MODE_STEP_OV, 32'h0, 1'b0, 4'd1);
        send(MODE_INSTR, 32'h0000_1000, 1'b1, 4'd15);
        // arm the return address, then a second step over is ignored
        send(MODE_STEP_OV, 32'h0, 1'b0, 4'd1);
        send(MODE_STEP_OV, 32'h0, 1'b0, 4'd1);
        send(MODE_INSTR, 32'h0000_2000, 1'b0, 4'd2);
        send(MODE_INSTR, 32'h0000_100F, 1'b0, 4'd3);
        send(MODE_STEP_IN, 32'hFFFF_FFFF, 1'b1, 4'd15);
        send(MODE_RUN, 32'h0, 1'b0, 4'd1);
        send(MODE_INSTR, 32'hFFFF_FFFF, 1'b1, 4'd15);
        // add a breakpoint, hit it from running, disable it, miss it
        send(MODE_TOGGLE, 32'hFFFF_FFFF, 1'b0, 4'd1);
        send(MODE_INSTR, 32'hFFFF_FFFF, 1'b0, 4'd8);
        send(MODE_RUN, 32'h0, 1'b0, 4'd1);
        send(MODE_TOGGLE, 32'hFFFF_FFFF, 1'b0, 4'd1);
        send(MODE_INSTR, 32'hFFFF_FFFF, 1'b0, 4'd8);
        // remove an entry, then remove it again with nothing left to find
        send(MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 4'd1);
        send(MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 4'd1);
        // terminated: no halt without a hit
        send(MODE_TERM, 32'h0, 1'b0, 4'd1);
        send(MODE_INSTR, 32'hFFFF_FFFA, 1'b1, 4'd15);
        send(MODE_UNUSED, 32'h5A5A_5A5A, 1'b1, 4'd7);
        // step over a call at the top of the address space: target wraps
        send(MODE_STEP_OV, 32'h0, 1'b0, 4'd1);
        send(MODE_INSTR, 32'h0000_0009, 1'b0, 4'd1);
        // a hit forces single-step even from terminated
        send(MODE_TOGGLE, 32'h0000_0009, 1'b0, 4'd1);
        send(MODE_TERM, 32'h0, 1'b0, 4'd1);
        send(MODE_INSTR, 32'h0000_0009, 1'b0, 4'd1);

        // Random phases, each under its own break_on_entry setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            if (ph < 2)
                boot_single = ph[0];
            else
                boot_single = 1'($urandom_range(0, 1));
            load_break_on_entry(boot_single);
            calm = (ph == 3);
            if (ph == 5)
                stall_request = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        settle();
        if (mismatches == 0)
            $display("tb_breakpoint_step_controller_core: done, clean");
        else
            $display("tb_breakpoint_step_controller_core: done, errors");
        $finish;
    end

endmodule
